// ===== sv/spq_pkg.sv =====
// Shared constants, request codes and entry types for the stable priority queue.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int INDEX_BITS    = 10;
  localparam int ATTR_BITS     = 8;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int OP_BITS       = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]    index;
    logic [PRIORITY_BITS-1:0] prio;
    logic [ATTR_BITS-1:0]     attribute;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    entry_t item;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/spq_if.sv =====
// Valid/ready channel interfaces for requests and status results.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if
  import spq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [OP_BITS-1:0]       op;
  logic [INDEX_BITS-1:0]    item_index;
  logic [PRIORITY_BITS-1:0] item_priority;
  logic [ATTR_BITS-1:0]     item_attribute;

  modport source (output valid, op, item_index, item_priority, item_attribute,
                  input ready);
  modport sink   (input valid, op, item_index, item_priority, item_attribute,
                  output ready);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     head_valid;
  logic [INDEX_BITS-1:0]    head_index;
  logic [PRIORITY_BITS-1:0] head_priority;
  logic [ATTR_BITS-1:0]     head_attribute;
  logic [COUNT_BITS-1:0]    entry_count;
  logic                     push_dropped;

  modport source (output valid, head_valid, head_index, head_priority,
                  head_attribute, entry_count, push_dropped,
                  input ready);
  modport sink   (input valid, head_valid, head_index, head_priority,
                  head_attribute, entry_count, push_dropped,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and its valid bit, shifts with neighbors.
// Depends on spq_pkg for entry and command types.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_cmd_t cmd,
  input  wire entry_t    prev_entry,
  input  wire logic      prev_valid,
  input  wire logic      prev_ge,
  input  wire entry_t    next_entry,
  input  wire logic      next_valid,
  output entry_t         entry,
  output logic           valid,
  output logic           ge
);

  // Slot stays ahead of a new entry of equal or lower priority.
  assign ge = valid && (entry.prio >= cmd.item.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.push) begin
      valid <= valid | prev_valid;
    end else if (cmd.pop) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !ge) begin
      entry <= prev_ge ? cmd.item : prev_entry;
    end else if (cmd.pop) begin
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stable_priority_queue.sv =====
// Top level: bounded stable priority queue built as a chain of sorted cells.
// Depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell.
//
//   channel  dir  payload
//   req      in   op, item_index, item_priority, item_attribute
//   rsp      out  head_valid, head_index, head_priority, head_attribute,
//                 entry_count, push_dropped
//
// One request per cycle while results are taken: every cell compares against the new
// priority in parallel and shifts with its neighbor in the same cycle; the result
// follows in the next cycle. The result is held in registers, so a new request is
// taken in the cycle its predecessor's result transfers. Reset is synchronous and
// empties the queue. A stalled result stalls requests; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  logic                  out_valid;
  logic                  dropped;
  logic [COUNT_BITS-1:0] occupancy;
  logic [COUNT_BITS-1:0] occupancy_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  op_t                   op;
  cell_cmd_t             cmd;

  entry_t                cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_ge;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = op_t'(req.op);
  assign full      = (occupancy == COUNT_BITS'(QUEUE_DEPTH));
  assign empty     = (occupancy == '0);

  always_comb begin
    cmd.push           = accept && (op == OP_PUSH) && !full;
    cmd.pop            = accept && (op == OP_POP) && !empty;
    cmd.clear          = accept && (op == OP_CLEAR);
    cmd.item.index     = req.item_index;
    cmd.item.prio      = req.item_priority;
    cmd.item.attribute = req.item_attribute;
  end

  always_comb begin
    occupancy_next = occupancy;
    if (cmd.clear) begin
      occupancy_next = '0;
    end else if (cmd.push) begin
      occupancy_next = occupancy + COUNT_BITS'(1);
    end else if (cmd.pop) begin
      occupancy_next = occupancy - COUNT_BITS'(1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_t prev_entry;
      logic   prev_valid;
      logic   prev_ge;
      entry_t next_entry;
      logic   next_valid;

      if (i == 0) begin : g_first
        assign prev_entry = '0;
        assign prev_valid = 1'b1;
        assign prev_ge    = 1'b1;
      end else begin : g_inner
        assign prev_entry = cell_entry[i-1];
        assign prev_valid = cell_valid[i-1];
        assign prev_ge    = cell_ge[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign next_entry = '0;
        assign next_valid = 1'b0;
      end else begin : g_mid
        assign next_entry = cell_entry[i+1];
        assign next_valid = cell_valid[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .prev_entry (prev_entry),
        .prev_valid (prev_valid),
        .prev_ge    (prev_ge),
        .next_entry (next_entry),
        .next_valid (next_valid),
        .entry      (cell_entry[i]),
        .valid      (cell_valid[i]),
        .ge         (cell_ge[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      occupancy <= '0;
      dropped   <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        occupancy <= occupancy_next;
        dropped   <= (op == OP_PUSH) && full;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.head_valid     = cell_valid[0];
  assign rsp.head_index     = cell_valid[0] ? cell_entry[0].index : '0;
  assign rsp.head_priority  = cell_valid[0] ? cell_entry[0].prio : '0;
  assign rsp.head_attribute = cell_valid[0] ? cell_entry[0].attribute : '0;
  assign rsp.entry_count    = occupancy;
  assign rsp.push_dropped   = dropped;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for stable_priority_queue: directed and random
// push/pop/clear/nop traffic against a sorted-queue predictor, with random idling.
// Depends on spq_pkg, spq_req_if/spq_rsp_if and the stable_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int MAX_GAP      = 5;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 40;

  typedef struct {
    logic [INDEX_BITS-1:0]    item_idx;
    logic [PRIORITY_BITS-1:0] item_prio;
    logic [ATTR_BITS-1:0]     item_attr;
  } queue_slot_t;

  typedef struct {
    logic                     head_valid;
    logic [INDEX_BITS-1:0]    head_index;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [ATTR_BITS-1:0]     head_attribute;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     push_dropped;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_slot_t   model_slots [QUEUE_DEPTH];
  int            model_count = 0;
  queue_status_t pending_status [$];
  int            error_count = 0;
  int            idle_cycles = 0;
  bit            sender_gaps = 1'b1;
  bit            receiver_gaps = 1'b1;
  int            rsp_hold_len = 0;

  function automatic queue_status_t apply_request(
    input logic [OP_BITS-1:0]       op,
    input logic [INDEX_BITS-1:0]    idx,
    input logic [PRIORITY_BITS-1:0] prio,
    input logic [ATTR_BITS-1:0]     attr
  );
    queue_status_t st;
    int            pos;
    logic          dropped;
    dropped = 1'b0;
    case (op)
      OP_PUSH: begin
        if (model_count >= QUEUE_DEPTH) begin
          dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < model_count && model_slots[pos].item_prio >= prio) pos++;
          for (int i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
          model_slots[pos].item_idx  = idx;
          model_slots[pos].item_prio = prio;
          model_slots[pos].item_attr = attr;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count > 0) begin
          for (int i = 0; i + 1 < model_count; i++) model_slots[i] = model_slots[i+1];
          model_count--;
        end
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: ;
    endcase
    if (model_count > 0) begin
      st.head_valid     = 1'b1;
      st.head_index     = model_slots[0].item_idx;
      st.head_priority  = model_slots[0].item_prio;
      st.head_attribute = model_slots[0].item_attr;
    end else begin
      st.head_valid     = 1'b0;
      st.head_index     = '0;
      st.head_priority  = '0;
      st.head_attribute = '0;
    end
    st.entry_count  = COUNT_BITS'(model_count);
    st.push_dropped = dropped;
    return st;
  endfunction

  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0, 1:    return PRIORITY_BITS'($urandom_range(0, 3));
      2:       return PRIORITY_BITS'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_request(
    input logic [OP_BITS-1:0]       op,
    input logic [INDEX_BITS-1:0]    idx,
    input logic [PRIORITY_BITS-1:0] prio,
    input logic [ATTR_BITS-1:0]     attr
  );
    int gap;
    gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.op             <= op;
    req_ch.item_index     <= idx;
    req_ch.item_priority  <= prio;
    req_ch.item_attribute <= attr;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    pending_status.push_back(apply_request(op, idx, prio, attr));
  endtask

  task automatic send_push(input logic [PRIORITY_BITS-1:0] prio);
    send_request(OP_PUSH, INDEX_BITS'($urandom_range(0, 1023)), prio,
                 ATTR_BITS'($urandom_range(0, 255)));
  endtask

  task automatic send_random(input int count, input int push_pct, input int pop_pct);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) send_push(pick_priority());
      else if (r < push_pct + pop_pct)
        send_request(OP_POP, INDEX_BITS'($urandom_range(0, 1023)),
                     PRIORITY_BITS'($urandom_range(0, 255)), ATTR_BITS'($urandom_range(0, 255)));
      else if (r < 97)
        send_request(OP_CLEAR, INDEX_BITS'($urandom_range(0, 1023)),
                     PRIORITY_BITS'($urandom_range(0, 255)), ATTR_BITS'($urandom_range(0, 255)));
      else
        send_request(OP_NOP, INDEX_BITS'($urandom_range(0, 1023)),
                     PRIORITY_BITS'($urandom_range(0, 255)), ATTR_BITS'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic test_empty_queue();
    send_request(OP_POP, '1, '1, '1);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_NOP, '1, '0, '1);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_request(OP_PUSH, '1, '1, '1);
    send_request(OP_PUSH, '0, '0, '0);
    send_request(OP_POP, '0, '0, '0);
    send_request(OP_POP, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_equal_priority_order();
    send_request(OP_PUSH, 10'd1, 8'd7, 8'h11);
    send_request(OP_PUSH, 10'd2, 8'd7, 8'h22);
    send_request(OP_PUSH, 10'd3, 8'd9, 8'h33);
    send_request(OP_PUSH, 10'd4, 8'd7, 8'h44);
    send_request(OP_POP, '0, '0, '0);
    send_request(OP_POP, '0, '0, '0);
    send_request(OP_CLEAR, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_queue();
    repeat (QUEUE_DEPTH) send_push(pick_priority());
    send_push(pick_priority());
    send_request(OP_POP, '0, '0, '0);
    send_push('1);
    send_push('0);
    send_request(OP_CLEAR, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_mix();
    send_random(250, 50, 40);
    wait_drained();
  endtask

  task automatic test_random_fill();
    send_random(200, 75, 18);
    wait_drained();
  endtask

  task automatic test_full_rate();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    send_random(80, 55, 40);
    wait_drained();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  task automatic test_output_stall();
    sender_gaps  = 1'b0;
    rsp_hold_len = HOLD_CYCLES;
    send_random(30, 60, 35);
    wait_drained();
    sender_gaps  = 1'b1;
  endtask

  // result side: random or forced stalls, check each transfer against the oldest expectation
  initial begin
    int            stall;
    queue_status_t want;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_hold_len > 0) begin
        stall        = rsp_hold_len;
        rsp_hold_len = 0;
      end else begin
        stall = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      if (pending_status.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        want = pending_status.pop_front();
        if (rsp_ch.head_valid !== want.head_valid) begin
          $error("head_valid: expected %0d, actual %0d", want.head_valid, rsp_ch.head_valid);
          error_count++;
        end
        if (rsp_ch.head_index !== want.head_index) begin
          $error("head_index: expected %0d, actual %0d", want.head_index, rsp_ch.head_index);
          error_count++;
        end
        if (rsp_ch.head_priority !== want.head_priority) begin
          $error("head_priority: expected %0d, actual %0d",
                 want.head_priority, rsp_ch.head_priority);
          error_count++;
        end
        if (rsp_ch.head_attribute !== want.head_attribute) begin
          $error("head_attribute: expected %0d, actual %0d",
                 want.head_attribute, rsp_ch.head_attribute);
          error_count++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp_ch.entry_count);
          error_count++;
        end
        if (rsp_ch.push_dropped !== want.push_dropped) begin
          $error("push_dropped: expected %0d, actual %0d",
                 want.push_dropped, rsp_ch.push_dropped);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.op             <= OP_NOP;
    req_ch.item_index     <= '0;
    req_ch.item_priority  <= '0;
    req_ch.item_attribute <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_field_extremes();
    test_equal_priority_order();
    test_full_queue();
    test_random_mix();
    test_random_fill();
    test_full_rate();
    test_output_stall();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
